>>> rtl/ascii_signed_integer_extractor_defines.svh
// assertion macros shared by the integer extractor modules
`ifndef ASCII_SIGNED_INTEGER_EXTRACTOR_DEFINES_SVH
`define ASCII_SIGNED_INTEGER_EXTRACTOR_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define ASIE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define ASIE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/asie_pkg.sv
// types, codes and constants of the signed integer extractor
package asie_pkg;

    // character codes
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_END_ONLY  = 2'd3;

    // register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BYTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_VALUES = 2'd2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [7:0] SKIP_BYTE_RESET = 8'd44;

    // magnitude limits, positive and negative, per range
    localparam logic [63:0] POS_LIMIT_32 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_LIMIT_32 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] POS_LIMIT_64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT_64 = 64'h8000_0000_0000_0000;

    // queue between front and back
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_end;
    } asie_in_t;

    typedef struct packed {
        logic signed [63:0] number;
        logic [1:0]         status;
        logic               final_res;
    } asie_out_t;

    // one closed run, as handed from front to back
    typedef struct packed {
        logic [63:0] magnitude;
        logic        saw_digit;
        logic        is_negative;
        logic        range_exceeded;
        logic        wide_values;
        logic        end_only;
        logic        final_res;
    } asie_cmd_t;

endpackage

>>> rtl/ascii_signed_integer_extractor.sv
// top level: signed decimal integer extractor over a byte stream
// a word that closes a run or ends a string is written into the queue and from there
//   into the output register that drives m_valid; other words give no result
// throughput: one byte per cycle while the queue has room, set by the accumulate-by-ten add in the front
// a two-entry queue and the output register let both sides stall independently
// reset clears run state and queue, and sets registers to skip off, comma, 32-bit
module ascii_signed_integer_extractor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  asie_pkg::asie_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output asie_pkg::asie_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [asie_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asie_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                 fifo_full;
    logic                 fifo_empty;
    logic                 push;
    logic                 pop;
    asie_pkg::asie_cmd_t  push_cmd;
    asie_pkg::asie_cmd_t  pop_cmd;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    asie_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .in_ready  (s_ready),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    asie_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (fifo_empty)
    );

    asie_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .cmd        (pop_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> rtl/asie_front.sv
// front end: config registers, byte classification and run accumulation
`include "ascii_signed_integer_extractor_defines.svh"

module asie_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [asie_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asie_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    input  asie_pkg::asie_in_t                in_data,
    output logic                              in_ready,
    input  logic                              fifo_full,
    output logic                              push,
    output asie_pkg::asie_cmd_t               cmd
);

    logic        skip_enable_reg;
    logic [7:0]  skip_byte_reg;
    logic        wide_values_reg;

    logic        run_open_reg, run_open_next;
    logic        saw_digit_reg, saw_digit_next;
    logic        is_negative_reg, is_negative_next;
    logic [63:0] magnitude_reg, magnitude_next;
    logic        range_exceeded_reg, range_exceeded_next;

    logic        in_acc;
    logic        is_digit;
    logic        skipped;
    logic        emit;
    logic [3:0]  digit;
    logic [67:0] acc_sum;
    logic        acc_ovf;

    // updated run state after this word
    logic        upd_open;
    logic        upd_saw;
    logic        upd_neg;
    logic [63:0] upd_mag;
    logic        upd_rexc;

    assign in_ready = !fifo_full;
    assign in_acc   = in_valid && in_ready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_enable_reg <= 1'b0;
            skip_byte_reg   <= asie_pkg::SKIP_BYTE_RESET;
            wide_values_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                asie_pkg::CFG_SKIP_ENABLE: skip_enable_reg <= cfg_data[0];
                asie_pkg::CFG_SKIP_BYTE:   skip_byte_reg   <= cfg_data[7:0];
                asie_pkg::CFG_WIDE_VALUES: wide_values_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // classify the byte
    assign is_digit = (in_data.text_byte >= asie_pkg::CHAR_ZERO) &&
                      (in_data.text_byte <= asie_pkg::CHAR_NINE);
    assign skipped  = skip_enable_reg && (in_data.text_byte == skip_byte_reg);
    assign digit    = in_data.text_byte[3:0];

    // magnitude times ten plus digit, with carry-out as overflow
    assign acc_sum = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                   + {64'd0, digit};
    assign acc_ovf = |acc_sum[67:64];

    // run state update
    always_comb begin
        upd_open = run_open_reg;
        upd_saw  = saw_digit_reg;
        upd_neg  = is_negative_reg;
        upd_mag  = magnitude_reg;
        upd_rexc = range_exceeded_reg;
        emit     = in_data.string_end;
        if (is_digit) begin
            upd_open = 1'b1;
            upd_saw  = 1'b1;
            if (!range_exceeded_reg) begin
                if (acc_ovf) begin
                    upd_rexc = 1'b1;
                end else begin
                    upd_mag = acc_sum[63:0];
                end
            end
        end else if (!skipped && run_open_reg) begin
            emit = 1'b1;
        end else if (!skipped && (in_data.text_byte == asie_pkg::MINUS_CHAR)) begin
            upd_open = 1'b1;
            upd_neg  = 1'b1;
        end
    end

    // closed run handed to the queue
    always_comb begin
        cmd.magnitude      = upd_mag;
        cmd.saw_digit      = upd_saw;
        cmd.is_negative    = upd_neg;
        cmd.range_exceeded = upd_rexc;
        cmd.wide_values    = wide_values_reg;
        cmd.end_only       = !upd_open;
        cmd.final_res      = in_data.string_end;
    end

    assign push = in_acc && emit;

    // next state: cleared after every emit
    always_comb begin
        run_open_next       = run_open_reg;
        saw_digit_next      = saw_digit_reg;
        is_negative_next    = is_negative_reg;
        magnitude_next      = magnitude_reg;
        range_exceeded_next = range_exceeded_reg;
        if (in_acc) begin
            if (emit) begin
                run_open_next       = 1'b0;
                saw_digit_next      = 1'b0;
                is_negative_next    = 1'b0;
                magnitude_next      = '0;
                range_exceeded_next = 1'b0;
            end else begin
                run_open_next       = upd_open;
                saw_digit_next      = upd_saw;
                is_negative_next    = upd_neg;
                magnitude_next      = upd_mag;
                range_exceeded_next = upd_rexc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg       <= 1'b0;
            saw_digit_reg      <= 1'b0;
            is_negative_reg    <= 1'b0;
            magnitude_reg      <= '0;
            range_exceeded_reg <= 1'b0;
        end else begin
            run_open_reg       <= run_open_next;
            saw_digit_reg      <= saw_digit_next;
            is_negative_reg    <= is_negative_next;
            magnitude_reg      <= magnitude_next;
            range_exceeded_reg <= range_exceeded_next;
        end
    end

    // checks
    `ASIE_ASSERT_NXT(a_run_cleared, push, !run_open_reg && (magnitude_reg == '0), "run not cleared after emit")
    `ASIE_ASSERT_IMP(a_digit_implies_open, saw_digit_reg || is_negative_reg, run_open_reg, "run flags without open run")

endmodule

>>> rtl/asie_fifo.sv
// short queue of closed runs between front and back
`include "ascii_signed_integer_extractor_defines.svh"

module asie_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  asie_pkg::asie_cmd_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output asie_pkg::asie_cmd_t  pop_data,
    output logic                 empty
);

    asie_pkg::asie_cmd_t                   entry_reg [asie_pkg::FIFO_DEPTH];
    logic [asie_pkg::FIFO_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [asie_pkg::FIFO_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [asie_pkg::FIFO_CNT_W-1:0]       count_reg, count_next;
    logic                                  do_push;
    logic                                  do_pop;

    assign full     = (count_reg == asie_pkg::FIFO_CNT_W'(asie_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // checks
    `ASIE_ASSERT_IMP(a_no_push_when_full, push, !full, "push into full queue")
    `ASIE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= asie_pkg::FIFO_CNT_W'(asie_pkg::FIFO_DEPTH), "fill count beyond depth")

endmodule

>>> rtl/asie_back.sv
// back end: range check, sign and output register
`include "ascii_signed_integer_extractor_defines.svh"

module asie_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fifo_empty,
    input  asie_pkg::asie_cmd_t  cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output asie_pkg::asie_out_t  m_data
);

    logic                 m_valid_reg, m_valid_next;
    asie_pkg::asie_out_t  m_data_reg;
    asie_pkg::asie_out_t  result;
    logic [63:0]          limit;
    logic [63:0]          neg_mag;
    logic                 out_of_range;
    logic                 load;

    // output register takes a new word when empty or being drained
    assign load = !m_valid_reg || m_ready;
    assign pop  = load && !fifo_empty;

    // limit for the selected range and sign
    always_comb begin
        case ({cmd.wide_values, cmd.is_negative})
            2'b00:   limit = asie_pkg::POS_LIMIT_32;
            2'b01:   limit = asie_pkg::NEG_LIMIT_32;
            2'b10:   limit = asie_pkg::POS_LIMIT_64;
            2'b11:   limit = asie_pkg::NEG_LIMIT_64;
            default: limit = asie_pkg::POS_LIMIT_32;
        endcase
    end

    assign out_of_range = cmd.range_exceeded || (cmd.magnitude > limit);
    assign neg_mag      = 64'd0 - cmd.magnitude;

    // status and value
    always_comb begin
        result.number    = '0;
        result.final_res = cmd.final_res;
        if (cmd.end_only) begin
            result.status = asie_pkg::ST_END_ONLY;
        end else if (!cmd.saw_digit) begin
            result.status = asie_pkg::ST_NO_DIGITS;
        end else if (out_of_range) begin
            result.status = asie_pkg::ST_RANGE;
        end else begin
            result.status = asie_pkg::ST_OK;
            result.number = cmd.is_negative ? neg_mag : cmd.magnitude;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = !fifo_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `ASIE_ASSERT_IMP(a_zero_unless_ok, m_valid_reg && (m_data_reg.status != asie_pkg::ST_OK), m_data_reg.number == '0, "nonzero number on error status")
    `ASIE_ASSERT_IMP(a_end_only_final, m_valid_reg && (m_data_reg.status == asie_pkg::ST_END_ONLY), m_data_reg.final_res, "end-only word without final mark")

endmodule

>>> dv/ascii_signed_integer_extractor_tb.sv
// self-checking testbench for the signed decimal integer extractor
`timescale 1ns / 1ps

module ascii_signed_integer_extractor_tb;

    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned PHASE_WORDS   = 200;
    localparam int unsigned MAX_WAIT      = 16;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam logic [63:0] RADIX         = 64'd10;
    localparam logic [63:0] MAG_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

    // result given in a table row, used instead of the predictor
    typedef struct packed {
        bit                  typed;
        bit                  has_res;
        asie_pkg::asie_out_t res;
    } given_res_t;

    typedef struct packed {
        logic [7:0]         chr;
        bit                 fin;
        bit                 typed;
        bit                 has_res;
        logic signed [63:0] num;
        logic [1:0]         st;
        bit                 fr;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_valid = 1'b0;
    logic                            s_ready;
    asie_pkg::asie_in_t              s_data  = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    asie_pkg::asie_out_t             m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [asie_pkg::CFG_IDX_W-1:0]  cfg_index = asie_pkg::CFG_SKIP_ENABLE;
    logic [asie_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    given_res_t word_given = '0;

    // predictor state and its copy of the registers
    bit          acc_open;
    bit          acc_digit;
    bit          acc_neg;
    logic [63:0] acc_mag;
    bit          acc_ovf;
    bit          set_skip_en;
    logic [7:0]  set_skip_chr;
    bit          set_wide;

    asie_pkg::asie_out_t pending_results [$];
    logic [7:0]          txt_q [$];
    int unsigned mismatch_count = 0;
    int unsigned words_sent     = 0;
    int unsigned quiet          = 0;
    bit          sender_calm    = 1'b0;

    // directed words: empty string, lone minus, minus inside a run, skip byte off,
    // bytes either side of the digits, high bytes, end byte closing a run
    dir_row_t dir_rows [24] = '{
        '{8'h0A,                1, 1, 1, 0, asie_pkg::ST_END_ONLY,  1},
        '{asie_pkg::MINUS_CHAR, 0, 1, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h61,                0, 1, 1, 0, asie_pkg::ST_NO_DIGITS, 0},
        '{asie_pkg::CHAR_ZERO,  1, 1, 1, 0, asie_pkg::ST_OK,        1},
        '{asie_pkg::CHAR_NINE,  0, 0, 0, 0, asie_pkg::ST_OK,        0},
        '{asie_pkg::MINUS_CHAR, 0, 1, 1, 9, asie_pkg::ST_OK,        0},
        '{asie_pkg::MINUS_CHAR, 0, 1, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h37,                0, 0, 0, 0, asie_pkg::ST_OK,        0},
        '{8'hFF,                0, 0, 0, 0, asie_pkg::ST_OK,        0},
        '{asie_pkg::MINUS_CHAR, 1, 1, 1, 0, asie_pkg::ST_NO_DIGITS, 1},
        '{8'h2C,                0, 1, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h31,                0, 0, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h2C,                0, 1, 1, 1, asie_pkg::ST_OK,        0},
        '{8'h35,                1, 1, 1, 5, asie_pkg::ST_OK,        1},
        '{8'h00,                0, 1, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h33,                0, 0, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h34,                1, 0, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h80,                1, 1, 1, 0, asie_pkg::ST_END_ONLY,  1},
        '{8'h38,                0, 0, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h7F,                1, 1, 1, 8, asie_pkg::ST_OK,        1},
        '{asie_pkg::MINUS_CHAR, 0, 1, 0, 0, asie_pkg::ST_OK,        0},
        '{asie_pkg::MINUS_CHAR, 0, 1, 1, 0, asie_pkg::ST_NO_DIGITS, 0},
        '{8'h2F,                0, 1, 0, 0, asie_pkg::ST_OK,        0},
        '{8'h3A,                1, 1, 1, 0, asie_pkg::ST_END_ONLY,  1}
    };

    ascii_signed_integer_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #6 aclk = ~aclk;

    // predictor: register and run state after reset
    function automatic void reset_model();
        set_skip_en  = 1'b0;
        set_skip_chr = asie_pkg::SKIP_BYTE_RESET;
        set_wide     = 1'b0;
        acc_open     = 1'b0;
        acc_digit    = 1'b0;
        acc_neg      = 1'b0;
        acc_mag      = '0;
        acc_ovf      = 1'b0;
    endfunction

    // predictor: value of the pending run, range checked now, then clear it
    function automatic asie_pkg::asie_out_t close_run(input bit last);
        asie_pkg::asie_out_t r;
        logic [63:0]         lim;
        r           = '0;
        r.final_res = last;
        if (acc_neg) lim = set_wide ? asie_pkg::NEG_LIMIT_64 : asie_pkg::NEG_LIMIT_32;
        else         lim = set_wide ? asie_pkg::POS_LIMIT_64 : asie_pkg::POS_LIMIT_32;
        if (!acc_digit) begin
            r.status = asie_pkg::ST_NO_DIGITS;
        end else if (acc_ovf || acc_mag > lim) begin
            r.status = asie_pkg::ST_RANGE;
        end else begin
            r.status = asie_pkg::ST_OK;
            r.number = acc_neg ? 64'd0 - acc_mag : acc_mag;
        end
        acc_open  = 1'b0;
        acc_digit = 1'b0;
        acc_neg   = 1'b0;
        acc_mag   = '0;
        acc_ovf   = 1'b0;
        return r;
    endfunction

    // predictor: one text byte in, returns 1 when it yields a value
    function automatic bit scan_byte(input asie_pkg::asie_in_t w,
                                     output asie_pkg::asie_out_t r);
        logic [63:0] dig;
        bit          skipped;
        r       = '0;
        skipped = set_skip_en && (w.text_byte == set_skip_chr);
        if (w.text_byte >= asie_pkg::CHAR_ZERO && w.text_byte <= asie_pkg::CHAR_NINE) begin
            dig = {60'd0, w.text_byte[3:0]};
            // magnitude freezes once it would pass 64 bits
            if (!acc_ovf) begin
                if (acc_mag > (MAG_MAX - dig) / RADIX) acc_ovf = 1'b1;
                else acc_mag = acc_mag * RADIX + dig;
            end
            acc_open  = 1'b1;
            acc_digit = 1'b1;
        end else if (!skipped && acc_open) begin
            r = close_run(w.string_end);
            return 1'b1;
        end else if (!skipped && w.text_byte == asie_pkg::MINUS_CHAR) begin
            acc_open = 1'b1;
            acc_neg  = 1'b1;
        end
        if (w.string_end) begin
            if (acc_open) begin
                r = close_run(1'b1);
            end else begin
                r.status    = asie_pkg::ST_END_ONLY;
                r.final_res = 1'b1;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // digits of one value, aimed around the 32- and 64-bit limits
    function automatic string number_text();
        string       s;
        logic [63:0] v;
        int unsigned n;
        case ($urandom_range(0, 9))
            0, 1, 2: s = $sformatf("%0d", $urandom_range(0, 999));
            3: s = $sformatf("%0d", 64'd2147483646 + $urandom_range(0, 3));
            4: s = $sformatf("%0d", 64'h7FFF_FFFF_FFFF_FFFE + $urandom_range(0, 3));
            5: s = $sformatf("1844674407370955161%0d", $urandom_range(4, 9));
            6: begin
                v = {$urandom, $urandom};
                s = $sformatf("%0d", v);
            end
            7: s = {"000", $sformatf("%0d", $urandom_range(0, 99))};
            8: begin
                n = $urandom_range(1, 24);
                s = "";
                repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
            default: s = $sformatf("%0d", $urandom);
        endcase
        return s;
    endfunction

    // digits with the skip byte sprinkled in when skipping is on
    function automatic void add_digits(input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (i > 0 && set_skip_en && $urandom_range(0, 5) == 0)
                txt_q = {txt_q, set_skip_chr};
            txt_q = {txt_q, s[i]};
        end
    endfunction

    // byte between values
    function automatic logic [7:0] gap_char();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h0A;
            2:       return set_skip_chr;
            3:       return asie_pkg::MINUS_CHAR;
            4:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one string: mostly values and separators, some raw noise and stray minus signs
    function automatic void build_string();
        int unsigned ntok;
        txt_q.delete();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) txt_q = {txt_q, 8'($urandom_range(0, 255))};
            return;
        end
        ntok = $urandom_range(0, 4);
        for (int t = 0; t < ntok; t++) begin
            if (t > 0 || $urandom_range(0, 1) == 1) txt_q = {txt_q, gap_char()};
            if ($urandom_range(0, 7) == 0) begin
                txt_q = {txt_q, asie_pkg::MINUS_CHAR};
                if ($urandom_range(0, 1) == 1) txt_q = {txt_q, gap_char()};
            end else begin
                if ($urandom_range(0, 1) == 1) txt_q = {txt_q, asie_pkg::MINUS_CHAR};
                add_digits(number_text());
            end
        end
        if (ntok == 0 || $urandom_range(0, 1) == 1) txt_q = {txt_q, gap_char()};
    endfunction

    // one word on the input channel, after a random gap
    task automatic send_word(input asie_pkg::asie_in_t w, input given_res_t given);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_data     <= w;
        word_given <= given;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_text(input bit close_it);
        asie_pkg::asie_in_t w;
        foreach (txt_q[i]) begin
            w.text_byte  = txt_q[i];
            w.string_end = close_it && (i == txt_q.size() - 1);
            send_word(w, '0);
        end
    endtask

    // hold the input until every value has come out, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // cfg_valid stays high across back-to-back writes
    task automatic write_reg(input logic [asie_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // stimulus
    initial begin : stimulus
        asie_pkg::asie_in_t w;
        given_res_t         given;
        bit                 en_val;
        logic [7:0]         chr_val;
        bit                 wide_val;
        bit                 close_it;
        int unsigned        target;

        reset_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at reset settings
        foreach (dir_rows[i]) begin
            w.text_byte          = dir_rows[i].chr;
            w.string_end         = dir_rows[i].fin;
            given.typed          = dir_rows[i].typed;
            given.has_res        = dir_rows[i].has_res;
            given.res.number     = dir_rows[i].num;
            given.res.status     = dir_rows[i].st;
            given.res.final_res  = dir_rows[i].fr;
            send_word(w, given);
        end

        // random phases, each under its own register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin en_val = 1'b1; chr_val = 8'h2C;                wide_val = 1'b0; end
                1: begin en_val = 1'b1; chr_val = 8'h2C;                wide_val = 1'b1; end
                2: begin en_val = 1'b1; chr_val = asie_pkg::MINUS_CHAR; wide_val = 1'b1; end
                3: begin en_val = 1'b1; chr_val = 8'h35;                wide_val = 1'b0; end
                4: begin en_val = 1'b0; chr_val = 8'hFF;                wide_val = 1'b1; end
                5: begin en_val = 1'b1; chr_val = 8'h00;                wide_val = 1'b0; end
                6: begin en_val = 1'b1; chr_val = 8'hFF;                wide_val = 1'b0; end
                default: begin
                    en_val   = 1'($urandom_range(0, 1));
                    chr_val  = 8'($urandom_range(0, 255));
                    wide_val = 1'($urandom_range(0, 1));
                end
            endcase
            // upper data bits of the one-bit registers are don't-care
            write_reg(asie_pkg::CFG_SKIP_ENABLE, {7'($urandom), en_val});
            write_reg(asie_pkg::CFG_SKIP_BYTE, chr_val);
            write_reg(asie_pkg::CFG_WIDE_VALUES, {7'($urandom), wide_val});
            cfg_valid <= 1'b0;

            sender_calm = (p % 3 == 1);
            target      = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                build_string();
                // a string left open runs into the next settings
                close_it = (words_sent + txt_q.size() < target) || (p == NUM_PHASES - 1)
                           || ($urandom_range(0, 1) == 1);
                send_text(close_it);
                if ($urandom_range(0, 30) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("** ascii_signed_integer_extractor: PASSED **");
        else
            $display("** ascii_signed_integer_extractor: FAILED **");
        $finish;
    end

    // result side: random stalls, with calm stretches
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = (((taken / 40) % 3) == 2) ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    // register writes, predictions and value checks
    always @(posedge aclk) begin : check_results
        asie_pkg::asie_out_t want;
        asie_pkg::asie_out_t model_res;
        bit                  produced;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    asie_pkg::CFG_SKIP_ENABLE: set_skip_en  = cfg_data[0];
                    asie_pkg::CFG_SKIP_BYTE:   set_skip_chr = cfg_data;
                    asie_pkg::CFG_WIDE_VALUES: set_wide     = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected word: number %0d status %0d final %0d",
                             $time, m_data.number, m_data.status, m_data.final_res);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.number !== want.number) begin
                        $display("%0t: number: expected %0d, got %0d",
                                 $time, want.number, m_data.number);
                        mismatch_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status: expected %0d, got %0d",
                                 $time, want.status, m_data.status);
                        mismatch_count++;
                    end
                    if (m_data.final_res !== want.final_res) begin
                        $display("%0t: final_res: expected %0d, got %0d",
                                 $time, want.final_res, m_data.final_res);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                produced = scan_byte(s_data, model_res);
                if (word_given.typed) begin
                    if (word_given.has_res)
                        pending_results = {pending_results, word_given.res};
                end else if (produced) begin
                    pending_results = {pending_results, model_res};
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("** ascii_signed_integer_extractor: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
